// ===== rtl/xhdp_pkg.sv =====
// Shared types, constants and helper functions for the XBM hex data parser.
// No dependencies; every RTL file of the block imports this package.
`default_nettype none

package xhdp_pkg;

   // Register file of the configuration port.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_X10_FORMAT   = 2'd2;

   localparam logic [CSR_DATA_W-1:0] IMAGE_WIDTH_RST  = 13'd8;
   localparam logic [CSR_DATA_W-1:0] IMAGE_HEIGHT_RST = 13'd8;

   // Largest dimension a 13-bit register can carry.
   localparam int CFG_DIM_MAX = 8191;
   localparam int MAX_DIM_DEF = 4096;

   // Field widths.
   localparam int CHAR_W  = 8;
   localparam int BYTE_W  = 8;
   localparam int TOKEN_W = 16;
   localparam int EMIT_W  = 22;

   // Result queue.
   localparam int RSP_DEPTH = 4;

   // Characters that close a token.
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;

   typedef struct packed {
      logic              read_error;
      logic              image_done;
      logic              run_last;
      logic [BYTE_W-1:0] data_byte;
   } rsp_item_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[BYTE_W-1-i] = v[i];
      end
      return r;
   endfunction

   function automatic hex_digit_type hex_decode(input logic [CHAR_W-1:0] c);
      hex_digit_type d;
      d.valid = 1'b0;
      d.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.valid = 1'b1;
         d.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.valid = 1'b1;
         d.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.valid = 1'b1;
         d.value = 4'(c - 8'h57);
      end
      return d;
   endfunction

   function automatic logic is_delim(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_RBRACE) ||
             (c == CH_NEWLINE) || (c == CH_TAB);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/xbm_hex_data_parser.sv =====
// XBM hex data parser: one character per transaction in, bit-reversed data bytes out.
// Depends on xhdp_pkg for types, constants and the digit and bit-order helpers.
//
// The parser takes one character per clock cycle when ready. Each accepted character
// updates the token and position state in the same cycle and pushes zero, one or two
// result bytes into a four-entry result queue; the request side is ready while the queue
// holds at most two entries. X11 streams therefore run at one character per cycle, while
// X10 tokens that produce two bytes are limited by the result port, which drains one
// byte per cycle. Image size, bytes per line and padding are precomputed when the
// configuration registers change, so a request may follow a configuration write at once.
`default_nettype none

module xbm_hex_data_parser
   import xhdp_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] char_code
   input  wire logic                  req_tlast,   // end_of_file
   // Result channel.
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [7:0]            rsp_tdata,   // [7:0] data_byte
   output      logic                  rsp_tlast,   // run_last
   output      logic [1:0]            rsp_tuser,   // [0] image_done, [1] read_error
   // Configuration port.
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int W_MAX   = (MAX_DIM < CFG_DIM_MAX) ? MAX_DIM : CFG_DIM_MAX;
   localparam int DIM_W   = $clog2(W_MAX + 1);
   localparam int BPL_MAX = (W_MAX + 7) / 8 + 1;
   localparam int BPL_W   = $clog2(BPL_MAX + 1);
   localparam int LP_W    = $clog2(BPL_MAX);
   localparam int SUM_W   = $clog2(BPL_MAX + 2);
   localparam int SIZE_W  = $clog2(BPL_MAX * W_MAX + 1);
   localparam int CMP_W   = (SIZE_W > EMIT_W) ? SIZE_W : EMIT_W;
   localparam int PTR_W   = $clog2(RSP_DEPTH);
   localparam int CNT_W   = $clog2(RSP_DEPTH + 1);

   // Configuration registers and the geometry derived from them.
   logic [CSR_DATA_W-1:0] cfg_width_ff, cfg_width_in;
   logic [CSR_DATA_W-1:0] cfg_height_ff, cfg_height_in;
   logic                  cfg_x10_ff, cfg_x10_in;
   logic                  pad_ff, pad_in;
   logic [BPL_W-1:0]      bpl_ff, bpl_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [DIM_W-1:0]      dim_w, dim_h;

   // Parser state.
   logic [TOKEN_W-1:0] token_ff, token_in;
   logic               digit_seen_ff, digit_seen_in;
   logic [EMIT_W-1:0]  emitted_ff, emitted_in;
   logic [LP_W-1:0]    line_pos_ff, line_pos_in;
   logic               finished_ff, finished_in;

   // Result queue.
   rsp_item_type       rsp_q_ff [RSP_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               req_acc;
   logic               rsp_acc;
   logic               active;
   hex_digit_type      digit;
   logic [1:0]         push_cnt;
   rsp_item_type       item0, item1;
   rsp_item_type       head;
   logic [1:0]         step;
   logic               drop;
   logic               done;
   logic [EMIT_W-1:0]  emitted_next;
   logic [SUM_W-1:0]   line_sum;
   logic [SUM_W-1:0]   line_plus2;

   // ---------------------------------------------------------------- configuration
   always_comb begin
      cfg_width_in  = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      cfg_x10_in    = cfg_x10_ff;
      if (reset) begin
         cfg_width_in  = IMAGE_WIDTH_RST;
         cfg_height_in = IMAGE_HEIGHT_RST;
         cfg_x10_in    = 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH:  cfg_width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: cfg_height_in = csr_wdata;
            CSR_X10_FORMAT:   cfg_x10_in    = csr_wdata[0];
            default:          cfg_width_in  = cfg_width_ff;
         endcase
      end
   end

   // Geometry follows the next register values so it is current on the next edge.
   always_comb begin
      dim_w   = (32'(cfg_width_in) > W_MAX) ? DIM_W'(W_MAX) : DIM_W'(cfg_width_in);
      dim_h   = (32'(cfg_height_in) > W_MAX) ? DIM_W'(W_MAX) : DIM_W'(cfg_height_in);
      pad_in  = cfg_x10_in && (dim_w[3:0] != 4'd0) && (dim_w[3:0] < 4'd9);
      bpl_in  = BPL_W'((32'(dim_w) + 7) >> 3) + BPL_W'(pad_in);
      size_in = SIZE_W'(bpl_in) * SIZE_W'(dim_h);
   end

   always_ff @(posedge clock) begin
      cfg_width_ff  <= cfg_width_in;
      cfg_height_ff <= cfg_height_in;
      cfg_x10_ff    <= cfg_x10_in;
      pad_ff        <= pad_in;
      bpl_ff        <= bpl_in;
      size_ff       <= size_in;
   end

   // ---------------------------------------------------------------- parser
   assign req_tready = (count_ff <= CNT_W'(RSP_DEPTH - 2));
   assign req_acc    = req_tvalid && req_tready;
   assign active     = !finished_ff &&
                       !((size_ff != '0) && (CMP_W'(emitted_ff) >= CMP_W'(size_ff)));
   assign digit      = hex_decode(req_tdata);

   always_comb begin
      token_in      = token_ff;
      digit_seen_in = digit_seen_ff;
      emitted_in    = emitted_ff;
      line_pos_in   = line_pos_ff;
      finished_in   = finished_ff;
      push_cnt      = 2'd0;
      item0         = '0;
      item1         = '0;

      line_plus2   = SUM_W'(line_pos_ff) + SUM_W'(2);
      drop         = cfg_x10_ff ? (pad_ff && (line_plus2 >= SUM_W'(bpl_ff))) : 1'b1;
      step         = cfg_x10_ff ? 2'd2 : 2'd1;
      emitted_next = emitted_ff + EMIT_W'(step);
      line_sum     = SUM_W'(line_pos_ff) + SUM_W'(step);
      done         = CMP_W'(emitted_next) >= CMP_W'(size_ff);

      if (req_acc && active) begin
         if (req_tlast) begin
            // End of file before the image is complete; a partial token is discarded.
            finished_in      = 1'b1;
            token_in         = '0;
            digit_seen_in    = 1'b0;
            item0.read_error = 1'b1;
            item0.run_last   = 1'b1;
            push_cnt         = 2'd1;
         end else if (digit.valid) begin
            token_in      = {token_ff[TOKEN_W-5:0], digit.value};
            digit_seen_in = 1'b1;
         end else if (is_delim(req_tdata) && digit_seen_ff) begin
            token_in      = '0;
            digit_seen_in = 1'b0;
            if (size_ff != '0) begin
               emitted_in  = emitted_next;
               line_pos_in = (line_sum >= SUM_W'(bpl_ff)) ? '0 : LP_W'(line_sum);
               if (done) begin
                  finished_in = 1'b1;
               end
               item0.data_byte = flip8(token_ff[BYTE_W-1:0]);
               if (drop) begin
                  item0.run_last   = 1'b1;
                  item0.image_done = done;
                  push_cnt         = 2'd1;
               end else begin
                  item1.data_byte  = flip8(token_ff[TOKEN_W-1:BYTE_W]);
                  item1.run_last   = 1'b1;
                  item1.image_done = done;
                  push_cnt         = 2'd2;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff      <= '0;
         digit_seen_ff <= 1'b0;
         emitted_ff    <= '0;
         line_pos_ff   <= '0;
         finished_ff   <= 1'b0;
      end else begin
         token_ff      <= token_in;
         digit_seen_ff <= digit_seen_in;
         emitted_ff    <= emitted_in;
         line_pos_ff   <= line_pos_in;
         finished_ff   <= finished_in;
      end
   end

   // ---------------------------------------------------------------- result queue
   assign head       = rsp_q_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = head.data_byte;
   assign rsp_tlast  = head.run_last;
   assign rsp_tuser  = {head.read_error, head.image_done};
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(rsp_acc);
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         rsp_q_ff[wr_ptr_ff] <= item0;
      end
      if (push_cnt == 2'd2) begin
         rsp_q_ff[wr_ptr_ff + PTR_W'(1)] <= item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // ---------------------------------------------------------------- assertions
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue holds more entries than it has");

   a_finished_sticks: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("finished flag cleared without reset");

   a_no_push_when_done: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> push_cnt == 2'd0)
      else $error("result produced after the image was finished");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && !rsp_tuser[0] && rsp_tdata == '0)
      else $error("error transaction carries data or a done flag");

   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      32'(line_pos_ff) < BPL_MAX)
      else $error("line position beyond the longest possible line");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the XBM hex data parser. Depends on xhdp_pkg and
// rtl/xbm_hex_data_parser.sv. Streams characters and register writes into the parser and
// checks each result byte against a built-in model, or a typed row's table bytes.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import xhdp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEM_TARGET    = 1250;
   localparam int CALM_FROM      = 1050;
   localparam int HOLD_AT        = 150;
   localparam int HOLD_CYCLES    = 120;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 16;

   localparam logic [CHAR_W-1:0] DELIMS [5] = '{CH_SPACE, CH_COMMA, CH_RBRACE, CH_NEWLINE,
                                                CH_TAB};

   // One row of the directed table: either a full register setting or a short text.
   // A typed row carries its expected result bytes for the text's last character.
   typedef struct packed {
      logic        is_cfg;
      logic [12:0] w;
      logic [12:0] h;
      logic        fmt;
      logic [63:0] text;
      logic        typed;
      logic [1:0]  n;
      logic [7:0]  b0;
      logic [7:0]  b1;
   } dir_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tlast;
   logic [1:0]            rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Model copy of the registers and the parser state.
   logic [12:0] img_w      = IMAGE_WIDTH_RST;
   logic [12:0] img_h      = IMAGE_HEIGHT_RST;
   logic        x10        = 1'b0;
   logic [15:0] token      = '0;
   logic        have_digit = 1'b0;
   logic [21:0] emitted    = '0;
   int          line_pos   = 0;
   logic        finished   = 1'b0;

   rsp_item_type expected_bytes [$];
   int           fails       = 0;
   int           item_count  = 0;
   int           rsp_count   = 0;
   int           stuck       = 0;
   bit           calm        = 1'b0;
   bit           sender_gaps = 1'b1;
   bit           counting    = 1'b1;

   xbm_hex_data_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int line_bytes(input int w, input logic fmt);
      int wc;
      int pad;
      wc  = (w > MAX_DIM_DEF) ? MAX_DIM_DEF : w;
      pad = (fmt && (wc % 16) != 0 && (wc % 16) < 9) ? 1 : 0;
      return (wc + 7) / 8 + pad;
   endfunction

   function automatic int image_bytes(input int w, input int h, input logic fmt);
      int hc;
      hc = (h > MAX_DIM_DEF) ? MAX_DIM_DEF : h;
      return line_bytes(w, fmt) * hc;
   endfunction

   // Advances the model by one character and returns how many result bytes it yields.
   function automatic int parse_char(input logic [7:0] c, input logic eof,
                                     output rsp_item_type r0, output rsp_item_type r1);
      int          bpl;
      int          sz;
      int          stp;
      logic        pad;
      logic        drop;
      logic        full;
      logic        is_hex;
      logic [3:0]  nib;
      logic [15:0] v;
      bpl    = line_bytes(int'(img_w), x10);
      // A padded line is one byte longer than the unpadded one.
      pad    = x10 && (bpl != line_bytes(int'(img_w), 1'b0));
      sz     = image_bytes(int'(img_w), int'(img_h), x10);
      r0     = '0;
      r1     = '0;
      is_hex = 1'b1;
      nib    = '0;
      if (finished || (sz > 0 && int'(emitted) >= sz)) return 0;
      if (eof) begin
         finished       = 1'b1;
         token          = '0;
         have_digit     = 1'b0;
         r0.run_last    = 1'b1;
         r0.read_error  = 1'b1;
         return 1;
      end
      if (c >= "0" && c <= "9") nib = 4'(c - "0");
      else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
      else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
      else is_hex = 1'b0;
      if (is_hex) begin
         token      = {token[11:0], nib};
         have_digit = 1'b1;
         return 0;
      end
      if (!(c == CH_SPACE || c == CH_COMMA || c == CH_RBRACE || c == CH_NEWLINE ||
            c == CH_TAB) || !have_digit) return 0;
      v          = token;
      token      = '0;
      have_digit = 1'b0;
      if (sz == 0) return 0;
      drop     = x10 ? (pad && line_pos + 2 >= bpl) : 1'b1;
      stp      = x10 ? 2 : 1;
      emitted  = emitted + 22'(stp);
      line_pos = line_pos + stp;
      if (line_pos >= bpl) line_pos = 0;
      full = int'(emitted) >= sz;
      if (full) finished = 1'b1;
      r0.data_byte = {<<{v[7:0]}};
      if (drop) begin
         r0.run_last   = 1'b1;
         r0.image_done = full;
         return 1;
      end
      r1.data_byte  = {<<{v[15:8]}};
      r1.run_last   = 1'b1;
      r1.image_done = full;
      return 2;
   endfunction

   function automatic dir_row_type cfg_row(input int w, input int h, input logic fmt);
      dir_row_type r;
      r        = '0;
      r.is_cfg = 1'b1;
      r.w      = 13'(w);
      r.h      = 13'(h);
      r.fmt    = fmt;
      return r;
   endfunction

   function automatic dir_row_type tok_row(input logic [63:0] text, input logic typed,
                                           input logic [1:0] n, input logic [7:0] b0,
                                           input logic [7:0] b1);
      dir_row_type r;
      r       = '0;
      r.text  = text;
      r.typed = typed;
      r.n     = n;
      r.b0    = b0;
      r.b1    = b1;
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_char(input logic [7:0] c, input logic eof, input logic typed = 1'b0,
                            input logic [1:0] n_typed = 2'd0, input logic [7:0] b0 = 8'h00,
                            input logic [7:0] b1 = 8'h00);
      rsp_item_type r0;
      rsp_item_type r1;
      int           n;
      if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tdata  <= c;
      req_tlast  <= eof;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      n = parse_char(c, eof, r0, r1);
      if (typed) begin
         n              = int'(n_typed);
         r0             = '0;
         r0.data_byte   = b0;
         r0.run_last    = (n_typed == 2'd1);
         r1             = '0;
         r1.data_byte   = b1;
         r1.run_last    = 1'b1;
      end
      if (n > 0) expected_bytes.push_back(r0);
      if (n > 1) expected_bytes.push_back(r1);
      if (counting) item_count++;
      if (item_count >= CALM_FROM) calm = 1'b1;
      @(negedge clock);
   endtask

   // Mostly well-formed tokens with random content; the rest is noise or broken tokens.
   task automatic send_token();
      int         nd;
      int         d;
      logic [7:0] c;
      if ($urandom_range(0, 9) == 0) begin
         send_char(8'($urandom_range(0, 255)), 1'b0);
         return;
      end
      if ($urandom_range(0, 3) == 0) begin
         send_char("0", 1'b0);
         send_char($urandom_range(0, 1) ? "x" : "X", 1'b0);
      end
      nd = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
      repeat (nd) begin
         d = $urandom_range(0, 15);
         if (d < 10) c = 8'("0" + d);
         else c = 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
         send_char(c, 1'b0);
         if ($urandom_range(0, 19) == 0) send_char(8'($urandom_range(0, 255)), 1'b0);
      end
      send_char(DELIMS[$urandom_range(0, 4)], 1'b0);
      if ($urandom_range(0, 3) == 0) send_char(DELIMS[$urandom_range(0, 4)], 1'b0);
   endtask

   // Waits until the parser has drained, then rewrites all three registers.
   task automatic set_config(input int w, input int h, input logic fmt);
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_IMAGE_WIDTH;
      csr_wdata <= 13'(w);
      @(negedge clock);
      csr_addr  <= CSR_IMAGE_HEIGHT;
      csr_wdata <= 13'(h);
      @(negedge clock);
      csr_addr  <= CSR_X10_FORMAT;
      csr_wdata <= 13'(fmt);
      @(negedge clock);
      csr_we    <= 1'b0;
      img_w = 13'(w);
      img_h = 13'(h);
      x10   = fmt;
   endtask

   initial begin : stimulus
      logic [7:0]  c;
      int          r;
      int          w;
      int          h;
      int          bpl;
      int          phase_end;
      logic        fmt;
      dir_row_type dir_tab [$];
      dir_tab = '{
         cfg_row(16, 4095, 1'b0),
         tok_row("FF,", 1'b1, 2'd1, 8'hFF, 8'h00),
         tok_row("80 ", 1'b1, 2'd1, 8'h01, 8'h00),
         tok_row("01\n", 1'b1, 2'd1, 8'h80, 8'h00),
         tok_row("x5a\t", 1'b1, 2'd1, 8'h5A, 8'h00),
         // Only the low byte of a long token survives in byte format.
         tok_row("12345}", 1'b1, 2'd1, 8'hA2, 8'h00),
         tok_row(",\377", 1'b1, 2'd0, 8'h00, 8'h00),
         tok_row("cD,", 1'b0, 2'd0, 8'h00, 8'h00),
         // Eight pixels in short format: every line end is padded, so the high byte drops.
         cfg_row(8, 4095, 1'b1),
         tok_row("FF01,", 1'b1, 2'd1, 8'h80, 8'h00),
         cfg_row(16, 4095, 1'b1),
         tok_row("0180,", 1'b1, 2'd2, 8'h01, 8'h80),
         tok_row("E\n", 1'b0, 2'd0, 8'h00, 8'h00)
      };
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_cfg) begin
            set_config(int'(dir_tab[i].w), int'(dir_tab[i].h), dir_tab[i].fmt);
         end else begin
            for (int k = 7; k >= 0; k--) begin
               c = dir_tab[i].text[k*8 +: 8];
               if (c != 8'h00) begin
                  send_char(c, 1'b0, dir_tab[i].typed && k == 0, dir_tab[i].n,
                            dir_tab[i].b0, dir_tab[i].b1);
               end
            end
         end
      end

      // Random phases. None of them may complete the image, since only one
      // image end can be seen per reset.
      while (item_count < ITEM_TARGET) begin
         r   = $urandom_range(0, 9);
         fmt = 1'($urandom_range(0, 1));
         w   = $urandom_range(1, 40);
         h   = $urandom_range(1000, 8191);
         case (r)
            0: begin
               case ($urandom_range(0, 4))
                  0:       w = 4096;
                  1:       w = 8191;
                  2:       w = 4095;
                  3:       w = 4088;
                  default: w = 4097;
               endcase
            end
            1: h = ($urandom_range(0, 1) != 0) ? 8191 : 4097;
            2: begin
               if ($urandom_range(0, 1) != 0) w = 0;
               else h = 0;
            end
            3: begin
               w = 1;
               h = 1;
            end
            default: ;
         endcase
         counting = image_bytes(w, h, fmt) > int'(emitted);
         if (counting && image_bytes(w, h, fmt) < int'(emitted) + 1000) h = 4096;
         sender_gaps = $urandom_range(0, 3) != 0;
         set_config(w, h, fmt);
         if (counting) begin
            phase_end = item_count + $urandom_range(60, 200);
            while (item_count < phase_end) send_token();
         end else begin
            repeat (8) send_token();
         end
      end

      counting = 1'b1;
      if ($urandom_range(0, 1) != 0) begin
         // Size the image so that it completes a few lines from here.
         fmt = 1'($urandom_range(0, 1));
         w   = $urandom_range(1, 40);
         bpl = line_bytes(w, fmt);
         set_config(w, int'(emitted) / bpl + 2, fmt);
         while (!finished) send_token();
      end else begin
         set_config($urandom_range(1, 40), 4096, 1'($urandom_range(0, 1)));
         repeat (4) send_token();
         // The partial token is discarded by the end of file.
         send_char("a", 1'b0);
         send_char("7", 1'b0);
         send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      // The parser is finished now and must ignore everything that follows.
      counting = 1'b0;
      repeat (3) send_token();
      send_char(8'($urandom_range(0, 255)), 1'b1);
      req_tvalid <= 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0) begin
         $display("PASS xbm_hex_data_parser");
      end else begin
         $display("FAIL xbm_hex_data_parser");
      end
      $finish;
   end

   initial begin : result_side
      int           hold;
      int           gap;
      bit           held;
      rsp_item_type got;
      rsp_item_type want;
      hold = 0;
      gap  = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tlast, rsp_tdata};
            rsp_count++;
            // One long hold-off, started while the sender is offering, lets the parser
            // fill up and stall its input.
            if (!held && rsp_count >= HOLD_AT && req_tvalid) begin
               held = 1'b1;
               hold = HOLD_CYCLES;
            end
            if (expected_bytes.size() == 0) begin
               $error("unexpected result transaction, data_byte %h", rsp_tdata);
               fails++;
            end else begin
               want = expected_bytes.pop_front();
               if (got.data_byte !== want.data_byte) begin
                  $error("data_byte: expected %h, actual %h", want.data_byte, got.data_byte);
                  fails++;
               end
               if (got.run_last !== want.run_last) begin
                  $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
                  fails++;
               end
               if (got.image_done !== want.image_done) begin
                  $error("image_done: expected %b, actual %b", want.image_done,
                         got.image_done);
                  fails++;
               end
               if (got.read_error !== want.read_error) begin
                  $error("read_error: expected %b, actual %b", want.read_error,
                         got.read_error);
                  fails++;
               end
            end
         end
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stuck = 0;
      else stuck++;
      if (stuck >= WATCHDOG_LIMIT) begin
         $display("FAIL xbm_hex_data_parser");
         $finish;
      end
   end

endmodule

`default_nettype wire
